// File: hw/rtl/fspe_pkg.sv
package fspe_pkg;

  // request codes carried on req_type
  typedef enum logic [2:0] {
    REQ_PUSH  = 3'd0,
    REQ_POP   = 3'd1,
    REQ_DEPTH = 3'd2,
    REQ_ROLL  = 3'd3,
    REQ_OVER  = 3'd4,
    REQ_PICK  = 3'd5,
    REQ_ROT   = 3'd6
  } req_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_OVER,
    S_FILL,
    S_ROT1,
    S_ROT2,
    S_ROT3,
    S_ROT4,
    S_PICK,
    S_SHIFT,
    S_LAST,
    S_FIN
  } state_t;

endpackage

// File: hw/rtl/fspe_ram.sv
module fspe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/forth_stack_permute_engine_unit.sv
// path to the result register: push, depth, the unused code, a too-large count and any pop or
// negative count that leaves the stack empty go straight to S_FIN; other pops, over, pick, roll 0
// and negative counts read the ram first (S_LOAD, S_OVER, S_PICK); rot runs S_ROT1 to S_ROT4; over
// or rot on a short stack runs S_FILL per written entry; roll by u > 0 runs S_PICK, S_SHIFT per
// shifted entry, then S_LAST. throughput: one transaction at a time; a finished result waits while
// the output register is still full, which holds off the request side. reset clears the state, the
// depth count and the result valid; the stack ram holds no valid data until written.
module forth_stack_permute_engine_unit #(
  parameter int STACK_DEPTH = 256,
  parameter int CELL_BITS   = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [2:0]         req_type,
  input  logic signed [31:0] push_value,
  output logic               res_valid,
  input  logic               res_ready,
  output logic signed [31:0] result_value,
  output logic [8:0]         depth_after,
  output logic               reverse_flag,
  output logic               overflow_flag
);

  // depth counter holds 0..STACK_DEPTH, ram address holds 0..STACK_DEPTH-1
  localparam int DW   = $clog2(STACK_DEPTH + 1);
  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int CMPW = (CELL_BITS > DW) ? CELL_BITS : DW;

  fspe_pkg::state_t state, state_next;

  logic [DW-1:0]        dcount, dcount_next;
  // cached copy of the top entry, valid whenever dcount is nonzero
  logic [CELL_BITS-1:0] top, top_next;
  // scratch cell: popped value, fill value or the item being moved
  logic [CELL_BITS-1:0] x, x_next;
  logic [AW-1:0]        ptr, ptr_next;
  logic [2:0]           op, op_next;
  logic                 rev, rev_next;
  logic                 ovf, ovf_next;

  // ram port signals
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [CELL_BITS-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [CELL_BITS-1:0] mem_rdata;

  logic                 fin_load;

  // decode helpers on the current stack
  logic [DW-1:0]        s;          // depth left after popping the count
  logic                 full;
  logic                 u_neg;
  logic                 u_big;
  logic [AW-1:0]        idx;
  logic [CELL_BITS-1:0] push_cell;

  assign s         = dcount - DW'(1);
  assign full      = (dcount == DW'(STACK_DEPTH));
  assign u_neg     = top[CELL_BITS-1];
  assign u_big     = (CMPW'(top) >= CMPW'(s));
  assign idx       = AW'(s - DW'(1) - DW'(top));
  // sign-extends into wide cells, truncates into narrow ones
  assign push_cell = CELL_BITS'(push_value);

  assign req_ready = (state == fspe_pkg::S_IDLE);

  fspe_ram #(
    .WIDTH(CELL_BITS),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= fspe_pkg::S_IDLE;
      dcount <= '0;
    end else begin
      state  <= state_next;
      dcount <= dcount_next;
    end
    top <= top_next;
    x   <= x_next;
    ptr <= ptr_next;
    op  <= op_next;
    rev <= rev_next;
    ovf <= ovf_next;
  end

  always_comb begin
    state_next  = state;
    dcount_next = dcount;
    top_next    = top;
    x_next      = x;
    ptr_next    = ptr;
    op_next     = op;
    rev_next    = rev;
    ovf_next    = ovf;
    mem_we      = 1'b0;
    mem_waddr   = AW'(dcount);
    mem_wdata   = top;
    mem_raddr   = ptr;
    fin_load    = 1'b0;

    unique case (state)
      fspe_pkg::S_IDLE: begin
        if (req_valid) begin
          op_next    = req_type;
          rev_next   = 1'b0;
          ovf_next   = 1'b0;
          state_next = fspe_pkg::S_FIN;
          unique case (req_type) inside
            fspe_pkg::REQ_PUSH: begin
              if (full) begin
                ovf_next = 1'b1;
              end else begin
                mem_we      = 1'b1;
                mem_waddr   = AW'(dcount);
                mem_wdata   = push_cell;
                top_next    = push_cell;
                dcount_next = dcount + DW'(1);
              end
            end
            fspe_pkg::REQ_DEPTH: begin
              if (full) begin
                ovf_next = 1'b1;
              end else begin
                mem_we      = 1'b1;
                mem_waddr   = AW'(dcount);
                mem_wdata   = CELL_BITS'(dcount);
                top_next    = CELL_BITS'(dcount);
                dcount_next = dcount + DW'(1);
              end
            end
            fspe_pkg::REQ_POP: begin
              if (dcount == '0) begin
                x_next = '0;
              end else begin
                x_next      = top;
                dcount_next = dcount - DW'(1);
                if (dcount >= DW'(2)) begin
                  mem_raddr  = AW'(dcount - DW'(2));
                  state_next = fspe_pkg::S_LOAD;
                end
              end
            end
            fspe_pkg::REQ_OVER: begin
              if (dcount < DW'(2)) begin
                // short stack: rebuild three entries, the old top lands in the middle
                ptr_next   = '0;
                x_next     = (dcount == DW'(1)) ? top : '0;
                state_next = fspe_pkg::S_FILL;
              end else begin
                mem_raddr  = AW'(dcount - DW'(2));
                state_next = fspe_pkg::S_OVER;
              end
            end
            fspe_pkg::REQ_ROT: begin
              if (dcount < DW'(3)) begin
                // short stack: with two entries only the new third entry is written
                ptr_next   = (dcount == DW'(2)) ? AW'(2) : '0;
                x_next     = (dcount == DW'(1)) ? top : '0;
                state_next = fspe_pkg::S_FILL;
              end else begin
                mem_raddr  = AW'(dcount - DW'(3));
                ptr_next   = AW'(dcount - DW'(3));
                state_next = fspe_pkg::S_ROT1;
              end
            end
            fspe_pkg::REQ_ROLL, fspe_pkg::REQ_PICK: begin
              if (dcount == '0) begin
                // empty stack pops a zero count, which is too large: push zero
                mem_we      = 1'b1;
                mem_waddr   = '0;
                mem_wdata   = '0;
                top_next    = '0;
                dcount_next = DW'(1);
              end else if (u_neg) begin
                rev_next    = 1'b1;
                dcount_next = s;
                if (dcount >= DW'(2)) begin
                  mem_raddr  = AW'(dcount - DW'(2));
                  state_next = fspe_pkg::S_LOAD;
                end
              end else if (u_big) begin
                // zero replaces the count slot, depth unchanged
                mem_we    = 1'b1;
                mem_waddr = AW'(s);
                mem_wdata = '0;
                top_next  = '0;
              end else begin
                mem_raddr  = idx;
                ptr_next   = idx;
                state_next = fspe_pkg::S_PICK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      fspe_pkg::S_LOAD: begin
        top_next   = mem_rdata;
        state_next = fspe_pkg::S_FIN;
      end

      fspe_pkg::S_OVER: begin
        if (full) begin
          ovf_next = 1'b1;
        end else begin
          mem_we      = 1'b1;
          mem_waddr   = AW'(dcount);
          mem_wdata   = mem_rdata;
          top_next    = mem_rdata;
          dcount_next = dcount + DW'(1);
        end
        state_next = fspe_pkg::S_FIN;
      end

      fspe_pkg::S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = ptr;
        mem_wdata = (ptr == AW'(1)) ? x : '0;
        if (ptr == AW'(2)) begin
          dcount_next = DW'(3);
          top_next    = '0;
          state_next  = fspe_pkg::S_FIN;
        end else begin
          ptr_next = ptr + AW'(1);
        end
      end

      // rot: a b c -> b c a, ptr points at a
      fspe_pkg::S_ROT1: begin
        x_next     = mem_rdata;
        mem_raddr  = ptr + AW'(1);
        state_next = fspe_pkg::S_ROT2;
      end

      fspe_pkg::S_ROT2: begin
        mem_we     = 1'b1;
        mem_waddr  = ptr;
        mem_wdata  = mem_rdata;
        state_next = fspe_pkg::S_ROT3;
      end

      fspe_pkg::S_ROT3: begin
        mem_we     = 1'b1;
        mem_waddr  = ptr + AW'(1);
        mem_wdata  = top;
        state_next = fspe_pkg::S_ROT4;
      end

      fspe_pkg::S_ROT4: begin
        mem_we     = 1'b1;
        mem_waddr  = ptr + AW'(2);
        mem_wdata  = x;
        top_next   = x;
        state_next = fspe_pkg::S_FIN;
      end

      // selected item is on the read port
      fspe_pkg::S_PICK: begin
        x_next   = mem_rdata;
        top_next = mem_rdata;
        if (op == fspe_pkg::REQ_PICK) begin
          // copy overwrites the count slot
          mem_we     = 1'b1;
          mem_waddr  = AW'(s);
          mem_wdata  = mem_rdata;
          state_next = fspe_pkg::S_FIN;
        end else begin
          dcount_next = s;
          if (DW'(ptr) + DW'(2) == dcount) begin
            // roll of the top item leaves the stack as it is
            state_next = fspe_pkg::S_FIN;
          end else begin
            mem_raddr  = ptr + AW'(1);
            state_next = fspe_pkg::S_SHIFT;
          end
        end
      end

      // move one entry down per cycle, read runs one address ahead of the write
      fspe_pkg::S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr;
        mem_wdata = mem_rdata;
        if (DW'(ptr) + DW'(2) == dcount) begin
          state_next = fspe_pkg::S_LAST;
        end else begin
          mem_raddr = ptr + AW'(2);
          ptr_next  = ptr + AW'(1);
        end
      end

      fspe_pkg::S_LAST: begin
        mem_we     = 1'b1;
        mem_waddr  = AW'(s);
        mem_wdata  = x;
        state_next = fspe_pkg::S_FIN;
      end

      // hand the result to the output register once it is free
      fspe_pkg::S_FIN: begin
        fin_load = !res_valid || res_ready;
        if (fin_load) begin
          state_next = fspe_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = fspe_pkg::S_IDLE;
      end
    endcase
  end

  // output register: holds a finished result while the next transaction is taken in
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fin_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
    if (fin_load) begin
      if (op == fspe_pkg::REQ_POP) begin
        result_value <= 32'(x);
      end else if (dcount != '0) begin
        result_value <= 32'(top);
      end else begin
        result_value <= '0;
      end
      depth_after   <= 9'(dcount);
      reverse_flag  <= rev;
      overflow_flag <= ovf;
    end
  end

endmodule
